### src/swvr_pkg.sv
// swvr_pkg: shared types and constants for the stack with value removal.
// Holds op and status codes, controller states and the controller/datapath
// command and status structs. No dependencies.
package swvr_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned CountWidth   = 7;
  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_TOP
  } state_e;

  // memory read address source
  typedef enum logic [2:0] {
    RD_CNT_M1,
    RD_CNT_M2,
    RD_PTR_M1,
    RD_PTR_P1,
    RD_PTR_P2
  } rd_sel_e;

  // memory write source
  typedef enum logic {
    WR_PUSH,
    WR_SHIFT
  } wr_sel_e;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_LOAD_TOP,
    PTR_DEC,
    PTR_INC
  } ptr_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_e;

  typedef enum logic [1:0] {
    TOT_HOLD,
    TOT_ADD_IN,
    TOT_SUB_TOP,
    TOT_SUB_VAL
  } tot_e;

  typedef enum logic [1:0] {
    TOP_HOLD,
    TOP_IN,
    TOP_ZERO,
    TOP_RD
  } top_e;

  typedef struct packed {
    logic    load;
    logic    mem_we;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    ptr_e    ptr;
    cnt_e    cnt;
    tot_e    tot;
    top_e    top;
    logic    finish;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one;
    logic match;
    logic ptr_zero;
    logic ptr_at_top;
    logic ptr_next_top;
  } stat_t;

endpackage

### src/swvr_ctrl.sv
// swvr_ctrl: sequencer for push, pop and search-and-remove.
// Drives swvr_dp through swvr_pkg::cmd_t and reads back swvr_pkg::stat_t.
module swvr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           op_i,
  input  swvr_pkg::stat_t      stat_i,
  output swvr_pkg::cmd_t       cmd_o,
  output logic                 busy_o
);

  swvr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swvr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swvr_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (swvr_pkg::op_e'(op_i))
            swvr_pkg::OP_POP: begin
              if (!stat_i.empty && !stat_i.one) state_d = swvr_pkg::S_TOP;
            end
            swvr_pkg::OP_REMOVE: begin
              if (!stat_i.empty) state_d = swvr_pkg::S_SCAN;
            end
            default: state_d = swvr_pkg::S_IDLE;
          endcase
        end
      end
      swvr_pkg::S_SCAN: begin
        if (stat_i.match) begin
          if (!stat_i.ptr_at_top) begin
            state_d = swvr_pkg::S_SHIFT;
          end else if (stat_i.one) begin
            state_d = swvr_pkg::S_IDLE;
          end else begin
            state_d = swvr_pkg::S_TOP;
          end
        end else if (stat_i.ptr_zero) begin
          state_d = swvr_pkg::S_IDLE;
        end
      end
      swvr_pkg::S_SHIFT: begin
        if (stat_i.ptr_next_top) state_d = swvr_pkg::S_IDLE;
      end
      swvr_pkg::S_TOP: state_d = swvr_pkg::S_IDLE;
      default: state_d = swvr_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.wr_sel = swvr_pkg::WR_PUSH;
    cmd_o.rd_sel = swvr_pkg::RD_CNT_M1;
    cmd_o.ptr    = swvr_pkg::PTR_HOLD;
    cmd_o.cnt    = swvr_pkg::CNT_HOLD;
    cmd_o.tot    = swvr_pkg::TOT_HOLD;
    cmd_o.top    = swvr_pkg::TOP_HOLD;
    cmd_o.status = swvr_pkg::ST_OK;
    busy_o       = (state_q != swvr_pkg::S_IDLE);
    unique case (state_q)
      swvr_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (swvr_pkg::op_e'(op_i))
            swvr_pkg::OP_PUSH: begin
              cmd_o.finish = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = swvr_pkg::ST_FULL;
              end else begin
                cmd_o.mem_we = 1'b1;
                cmd_o.wr_sel = swvr_pkg::WR_PUSH;
                cmd_o.cnt    = swvr_pkg::CNT_INC;
                cmd_o.tot    = swvr_pkg::TOT_ADD_IN;
                cmd_o.top    = swvr_pkg::TOP_IN;
              end
            end
            swvr_pkg::OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.finish = 1'b1;
                cmd_o.status = swvr_pkg::ST_EMPTY;
              end else begin
                cmd_o.cnt    = swvr_pkg::CNT_DEC;
                cmd_o.tot    = swvr_pkg::TOT_SUB_TOP;
                cmd_o.rd_sel = swvr_pkg::RD_CNT_M2;
                if (stat_i.one) begin
                  cmd_o.top    = swvr_pkg::TOP_ZERO;
                  cmd_o.finish = 1'b1;
                end
              end
            end
            swvr_pkg::OP_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.finish = 1'b1;
                cmd_o.status = swvr_pkg::ST_NOT_FOUND;
              end else begin
                cmd_o.rd_sel = swvr_pkg::RD_CNT_M1;
                cmd_o.ptr    = swvr_pkg::PTR_LOAD_TOP;
              end
            end
            default: cmd_o.finish = 1'b1;
          endcase
        end
      end
      swvr_pkg::S_SCAN: begin
        if (stat_i.match) begin
          cmd_o.tot = swvr_pkg::TOT_SUB_VAL;
          if (!stat_i.ptr_at_top) begin
            cmd_o.rd_sel = swvr_pkg::RD_PTR_P1;
          end else begin
            cmd_o.cnt    = swvr_pkg::CNT_DEC;
            cmd_o.rd_sel = swvr_pkg::RD_CNT_M2;
            if (stat_i.one) begin
              cmd_o.top    = swvr_pkg::TOP_ZERO;
              cmd_o.finish = 1'b1;
            end
          end
        end else if (stat_i.ptr_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = swvr_pkg::ST_NOT_FOUND;
        end else begin
          cmd_o.ptr    = swvr_pkg::PTR_DEC;
          cmd_o.rd_sel = swvr_pkg::RD_PTR_M1;
        end
      end
      swvr_pkg::S_SHIFT: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = swvr_pkg::WR_SHIFT;
        if (stat_i.ptr_next_top) begin
          cmd_o.cnt    = swvr_pkg::CNT_DEC;
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.ptr    = swvr_pkg::PTR_INC;
          cmd_o.rd_sel = swvr_pkg::RD_PTR_P2;
        end
      end
      swvr_pkg::S_TOP: begin
        cmd_o.top    = swvr_pkg::TOP_RD;
        cmd_o.finish = 1'b1;
      end
      default: cmd_o.finish = 1'b0;
    endcase
  end

endmodule

### src/swvr_dp.sv
// swvr_dp: entry memory, fill count, running total, top register and
// result registers. Uses swvr_pkg command/status structs; driven by swvr_ctrl.
module swvr_dp #(
  parameter int unsigned Depth = swvr_pkg::DefaultDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  swvr_pkg::cmd_t                         cmd_i,
  input  logic signed [swvr_pkg::DataWidth-1:0]  value_i,
  output swvr_pkg::stat_t                        stat_o,
  output logic                                   done_o,
  output logic [1:0]                             status_o,
  output logic signed [swvr_pkg::DataWidth-1:0]  top_value_o,
  output logic [swvr_pkg::CountWidth-1:0]        entry_count_o,
  output logic signed [swvr_pkg::DataWidth-1:0]  total_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned DW = swvr_pkg::DataWidth;

  logic [DW-1:0] mem [Depth];

  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [DW-1:0] total_q, total_d;
  logic signed [DW-1:0] top_q, top_d;
  logic [DW-1:0]        value_q;
  logic [DW-1:0]        rd_data_q;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [DW-1:0]        wr_data;
  logic                 done_q;
  swvr_pkg::status_e    status_q;

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      swvr_pkg::RD_CNT_M1: rd_addr = AW'(cnt_q - CW'(1));
      swvr_pkg::RD_CNT_M2: rd_addr = AW'(cnt_q - CW'(2));
      swvr_pkg::RD_PTR_M1: rd_addr = ptr_q - AW'(1);
      swvr_pkg::RD_PTR_P1: rd_addr = ptr_q + AW'(1);
      swvr_pkg::RD_PTR_P2: rd_addr = ptr_q + AW'(2);
      default:             rd_addr = ptr_q;
    endcase
  end

  assign wr_addr = (cmd_i.wr_sel == swvr_pkg::WR_PUSH) ? AW'(cnt_q) : ptr_q;
  assign wr_data = (cmd_i.wr_sel == swvr_pkg::WR_PUSH) ? value_i : rd_data_q;

  always_comb begin
    case (cmd_i.ptr)
      swvr_pkg::PTR_LOAD_TOP: ptr_d = AW'(cnt_q - CW'(1));
      swvr_pkg::PTR_DEC:      ptr_d = ptr_q - AW'(1);
      swvr_pkg::PTR_INC:      ptr_d = ptr_q + AW'(1);
      default:                ptr_d = ptr_q;
    endcase
    case (cmd_i.cnt)
      swvr_pkg::CNT_INC: cnt_d = cnt_q + CW'(1);
      swvr_pkg::CNT_DEC: cnt_d = cnt_q - CW'(1);
      default:           cnt_d = cnt_q;
    endcase
    case (cmd_i.tot)
      swvr_pkg::TOT_ADD_IN:  total_d = total_q + value_i;
      swvr_pkg::TOT_SUB_TOP: total_d = total_q - top_q;
      swvr_pkg::TOT_SUB_VAL: total_d = total_q - $signed(value_q);
      default:               total_d = total_q;
    endcase
    case (cmd_i.top)
      swvr_pkg::TOP_IN:   top_d = value_i;
      swvr_pkg::TOP_ZERO: top_d = '0;
      swvr_pkg::TOP_RD:   top_d = $signed(rd_data_q);
      default:            top_d = top_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      total_q  <= '0;
      top_q    <= '0;
      done_q   <= 1'b0;
      status_q <= swvr_pkg::ST_OK;
    end else begin
      cnt_q   <= cnt_d;
      total_q <= total_d;
      top_q   <= top_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.finish) begin
        status_q <= cmd_i.status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      value_q <= value_i;
    end
  end

  assign stat_o.full         = (cnt_q == CW'(Depth));
  assign stat_o.empty        = (cnt_q == '0);
  assign stat_o.one          = (cnt_q == CW'(1));
  assign stat_o.match        = (rd_data_q == value_q);
  assign stat_o.ptr_zero     = (ptr_q == '0);
  assign stat_o.ptr_at_top   = ((CW'(ptr_q) + CW'(1)) == cnt_q);
  assign stat_o.ptr_next_top = ((CW'(ptr_q) + CW'(2)) == cnt_q);

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign top_value_o   = top_q;
  assign entry_count_o = swvr_pkg::CountWidth'(cnt_q);
  assign total_o       = total_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("fill count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
    (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("fill count moved by more than one");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_we |-> (CW'(wr_addr) < cnt_q) ||
                     (cmd_i.wr_sel == swvr_pkg::WR_PUSH && CW'(wr_addr) == cnt_q))
    else $error("write outside held entries");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (top_q == '0))
    else $error("empty stack with nonzero top");
`endif

endmodule

### src/stack_with_value_removal_core.sv
// stack_with_value_removal_core: top level of the LIFO stack with search-and-remove.
// Instantiates swvr_ctrl and swvr_dp; types and constants from swvr_pkg.
//
//  - Issue an operation by raising start_i with op_i and value_i while busy_o
//    is low; the transfer happens at that clock edge. op_i: push, pop,
//    remove first match from the top, or no-op.
//  - Each operation yields one result: done_o is high for exactly one cycle
//    with status_o, top_value_o, entry_count_o and total_o. The receiver must
//    take it in that cycle; there is no backpressure.
//  - Push (accepted, or refused when full), no-op, pop of the last entry and
//    pop or remove on an empty stack strobe in the cycle after the accept
//    edge and keep busy_o low, so one may follow every cycle. A pop with
//    entries left below the popped one first fetches the new top in S_TOP.
//  - Remove scans from the top, one entry per cycle, to the first match or
//    down to the bottom (not found); S_SHIFT then moves each entry above the
//    match down, one per cycle, or S_TOP fetches the new top if it was removed.
//  - busy_o is high while the controller is out of S_IDLE; start_i is ignored
//    then, and the next op may be issued in the strobe cycle.
//  - Reset (rst_ni low, asynchronous) empties the stack: count, total and top
//    go to zero, no strobe; the entry memory is not cleared.
module stack_with_value_removal_core #(
  parameter int unsigned DEPTH = swvr_pkg::DefaultDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [1:0]                             op_i,
  input  logic signed [swvr_pkg::DataWidth-1:0]  value_i,
  output logic                                   done_o,
  output logic [1:0]                             status_o,
  output logic signed [swvr_pkg::DataWidth-1:0]  top_value_o,
  output logic [swvr_pkg::CountWidth-1:0]        entry_count_o,
  output logic signed [swvr_pkg::DataWidth-1:0]  total_o
);

  swvr_pkg::cmd_t  cmd;
  swvr_pkg::stat_t stat;

  // sequencer: decodes the op and steps through scan, shift and top fetch
  swvr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // storage and arithmetic; result ports are driven straight from registers
  swvr_dp #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (value_i),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .top_value_o   (top_value_o),
    .entry_count_o (entry_count_o),
    .total_o       (total_o)
  );

endmodule

### sim/stack_with_value_removal_core_tb.sv
// stack_with_value_removal_core_tb: self-checking testbench for the LIFO stack with
// search-and-remove. Depends on swvr_pkg and stack_with_value_removal_core only.
module stack_with_value_removal_core_tb;
  import swvr_pkg::*;

  localparam int StackDepth = DefaultDepth;
  // Longest legal wait with no transfer at all: a full-depth remove plus the
  // longest sender gap, taken several times over.
  localparam int IdleLimit  = 2000;
  localparam int PrintLimit = 30;

  typedef struct packed {
    status_e               status;
    logic [DataWidth-1:0]  top;
    logic [CountWidth-1:0] count;
    logic [DataWidth-1:0]  total;
  } outcome_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic [1:0]                   op_i;
  logic signed [DataWidth-1:0]  value_i;
  logic                         done_o;
  logic [1:0]                   status_o;
  logic signed [DataWidth-1:0]  top_value_o;
  logic [CountWidth-1:0]        entry_count_o;
  logic signed [DataWidth-1:0]  total_o;

  // Shadow stack: held[0] is the bottom, held[held_n-1] the top.
  logic [DataWidth-1:0] held [StackDepth];
  int                   held_n;
  logic [DataWidth-1:0] run_sum;

  outcome_t             pending_outcomes [$];
  // Values pushed lately; used to aim removes at entries that are likely held.
  logic [DataWidth-1:0] recent_values [$];

  int mismatch_count;
  int idle_cycles;
  bit gaps_on;

  stack_with_value_removal_core #(
    .DEPTH(StackDepth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .top_value_o  (top_value_o),
    .entry_count_o(entry_count_o),
    .total_o      (total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow stack and return the result it must
  // produce. Remove searches from the top and closes the gap below the top.
  function automatic outcome_t apply_stack_op(op_e op, logic [DataWidth-1:0] v);
    outcome_t o;
    int       k;
    o.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held_n >= StackDepth) begin
          o.status = ST_FULL;
        end else begin
          held[held_n] = v;
          held_n++;
          run_sum += v;
        end
      end
      OP_POP: begin
        if (held_n == 0) begin
          o.status = ST_EMPTY;
        end else begin
          held_n--;
          run_sum -= held[held_n];
        end
      end
      OP_REMOVE: begin
        k = held_n - 1;
        while (k >= 0 && held[k] != v) k--;
        if (k < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          run_sum -= held[k];
          for (int j = k; j < held_n - 1; j++) held[j] = held[j + 1];
          held_n--;
        end
      end
      default: ;
    endcase
    o.top   = (held_n > 0) ? held[held_n - 1] : '0;
    o.count = CountWidth'(held_n);
    o.total = run_sum;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [DataWidth-1:0] got,
                                 logic [DataWidth-1:0] want);
    if (mismatch_count < PrintLimit)
      $display("mismatch on %s: got %h, want %h", what, got, want);
    mismatch_count++;
  endtask

  // Check each result against the oldest expectation first, then record the
  // expectation of any transfer taken at this same edge.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing pending", status_o, '0);
        end else begin
          want = pending_outcomes.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (top_value_o !== want.top)
            report_mismatch("top_value", top_value_o, want.top);
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", entry_count_o, want.count);
          if (total_o !== want.total)
            report_mismatch("total", total_o, want.total);
        end
      end
      if (start_i && !busy_o)
        pending_outcomes.push_back(apply_stack_op(op_e'(op_i), value_i));
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one operation and hold it until the transfer happens. Call at a
  // rising edge; return at the edge of the transfer (or after the gap).
  task automatic send_op(op_e op, logic [DataWidth-1:0] v);
    int gap;
    start_i <= 1'b1;
    op_i    <= op;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic wait_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the value, wrap of the total, empty-stack refusals, the no-op
  // code, duplicates, and removal at the top, in the middle and at the bottom.
  // Leave the stack empty.
  task automatic test_edge_values();
    send_op(OP_POP, 32'h0000_0000);     // pop on empty
    send_op(OP_REMOVE, 32'h0000_0000);  // remove on empty
    send_op(OP_NOP, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'h0000_0001);    // total wraps to the most negative
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_PUSH, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 32'h5555_5555);
    send_op(OP_PUSH, 32'hAAAA_AAAA);
    send_op(OP_PUSH, 32'h0000_0001);    // duplicate of a deeper entry
    send_op(OP_NOP, 32'h0000_0000);
    send_op(OP_REMOVE, 32'h0000_0001);  // top matches first
    send_op(OP_REMOVE, 32'h0000_0001);  // deeper copy, shift the rest down
    send_op(OP_REMOVE, 32'h7FFF_FFFF);  // bottom entry
    send_op(OP_REMOVE, 32'h1234_5678);  // no match on a non-empty stack
    send_op(OP_REMOVE, 32'h8000_0000);
    send_op(OP_POP, 32'h0000_0000);
    send_op(OP_POP, 32'h0000_0000);
    send_op(OP_PUSH, 32'h0000_0000);
    send_op(OP_REMOVE, 32'h0000_0000);  // match on value zero
    send_op(OP_POP, 32'h0000_0000);
    send_op(OP_POP, 32'h0000_0000);     // empty again
  endtask

  // Fill to the limit with even values, push past it, then scan the full
  // stack without a match and remove the bottom entry (longest shift).
  // Expects an empty stack on entry and leaves one.
  task automatic test_fill_and_overflow();
    logic [DataWidth-1:0] bottom_val;
    logic [DataWidth-1:0] top_val;
    logic [DataWidth-1:0] v;
    bottom_val = '0;
    top_val    = '0;
    for (int i = 0; i < StackDepth; i++) begin
      v = $urandom() & ~32'd1;
      if (i == 0) bottom_val = v;
      top_val = v;
      send_op(OP_PUSH, v);
    end
    send_op(OP_PUSH, $urandom());        // full, dropped
    send_op(OP_PUSH, $urandom());
    send_op(OP_REMOVE, $urandom() | 32'd1); // odd value cannot match
    send_op(OP_REMOVE, bottom_val);
    send_op(OP_PUSH, $urandom() & ~32'd1);
    send_op(OP_POP, '0);
    send_op(OP_REMOVE, top_val);
    for (int i = 0; i <= StackDepth; i++) send_op(OP_POP, '0);
  endtask

  // Random traffic in segments that lean toward growth or shrink; removes
  // aim mostly at recently pushed values. One segment in four runs with no
  // gaps, and the sender pauses for a full drain halfway through.
  task automatic test_random_traffic(int n_items);
    int                   seg;
    int                   r;
    int                   idx;
    int                   push_bias;
    op_e                  op;
    logic [DataWidth-1:0] v;
    for (int i = 0; i < n_items; i++) begin
      seg       = i / 48;
      gaps_on   = (seg % 4 != 2);
      push_bias = (seg % 2 == 0) ? 65 : 25;
      r         = $urandom_range(0, 99);
      v         = $urandom();
      if (r < push_bias) begin
        op = OP_PUSH;
        // Small values now and then, so duplicates are held.
        if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 7);
        recent_values.push_back(v);
        if (recent_values.size() > StackDepth) void'(recent_values.pop_front());
      end else if (r < push_bias + 20) begin
        op = OP_POP;
        if (recent_values.size() > 0) void'(recent_values.pop_back());
      end else if (r < 96) begin
        op = OP_REMOVE;
        if (recent_values.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, recent_values.size() - 1);
          v   = recent_values[idx];
          recent_values.delete(idx);
        end else if ($urandom_range(0, 1) == 0) begin
          v = $urandom_range(0, 7);
        end
      end else begin
        op = OP_NOP;
      end
      send_op(op, v);
      if (i == n_items / 2) wait_until_drained();
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    op_i           <= OP_NOP;
    value_i        <= '0;
    held_n          = 0;
    run_sum         = '0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    gaps_on         = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_values();
    wait_until_drained();
    test_fill_and_overflow();
    wait_until_drained();
    test_random_traffic(480);
    wait_until_drained();

    // Catch any stray strobe after the last result.
    repeat (2 * StackDepth + 8) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      report_mismatch("results never returned", pending_outcomes.size(), '0);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
